// ----- hdl/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg: shared types and constants for the bracket-aware word splitter
// Holds the configuration, state and result records, the register index
// map, the error codes and the bracket character constants.
// ----------------------------------------------------------------------------
package pws_pkg;

  // Upper limit on nesting; the level is eight bits, so the limit is capped.
  localparam int MAX_NESTING = 255;
  localparam int LEVEL_LIMIT_INT = (MAX_NESTING > 255) ? 255 : MAX_NESTING;
  localparam logic [7:0] LEVEL_LIMIT = LEVEL_LIMIT_INT[7:0];

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_CHAR_A    = 3'd0,
    REG_SEP_CHAR_B    = 3'd1,
    REG_SEP_CHAR_C    = 3'd2,
    REG_SEP_CHAR_D    = 3'd3,
    REG_SEP_COUNT     = 3'd4,
    REG_BRACKET_KIND  = 3'd5,
    REG_DROP_BRACKETS = 3'd6,
    REG_CARRY_LEVEL   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_EXTRA_CLOSE = 2'd1,
    ERR_UNMATCHED   = 2'd2,
    ERR_OVERFLOW    = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    BK_ROUND  = 2'd0,
    BK_SQUARE = 2'd1,
    BK_CURLY  = 2'd2,
    BK_NONE   = 2'd3
  } bracket_kind_t;

  localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;

  localparam logic [7:0] RST_SEP_A = 8'd32;
  localparam logic [7:0] RST_SEP_B = 8'd9;
  localparam logic [7:0] RST_SEP_C = 8'd10;
  localparam logic [7:0] RST_SEP_D = 8'd0;
  localparam logic [2:0] RST_SEP_COUNT = 3'd3;

  typedef struct packed {
    logic [7:0]    sep_a;
    logic [7:0]    sep_b;
    logic [7:0]    sep_c;
    logic [7:0]    sep_d;
    logic [2:0]    sep_count;
    bracket_kind_t bracket_kind;
    logic          drop_brackets;
    logic          carry_level;
  } cfg_t;

  typedef struct packed {
    logic [7:0] nest_level;
    logic       word_open;
  } state_t;

  typedef struct packed {
    logic       char_kept;
    logic [7:0] char_out;
    logic       word_end;
    logic [7:0] level_out;
    err_t       error_code;
  } result_t;

endpackage

// ----- hdl/pws_step.sv -----
// ----------------------------------------------------------------------------
// pws_step: per-character classification logic
// Combinational evaluation of one character against the current nesting
// state; produces the result record and the state for the next character.
// ----------------------------------------------------------------------------
module pws_step (
  input  pws_pkg::cfg_t    cfg,
  input  logic [7:0]       char_in,
  input  logic             line_end,
  input  pws_pkg::state_t  state_cur,
  output pws_pkg::result_t result,
  output pws_pkg::state_t  state_nxt
);
  import pws_pkg::*;

  logic [7:0] open_c;
  logic [7:0] close_c;
  logic       bk_valid;
  logic       is_open;
  logic       is_close;
  logic       on_bracket;
  logic       is_sep;
  logic       err_close;
  logic       err_ovf;
  logic [7:0] lvl_a;
  logic [7:0] lvl_b;
  logic       found;
  logic       kept;
  logic       wo_mid;
  logic       wend;
  err_t       err;

  always_comb begin
    bk_valid = 1'b1;
    case (cfg.bracket_kind)
      BK_ROUND: begin
        open_c  = CH_ROUND_OPEN;
        close_c = CH_ROUND_CLOSE;
      end
      BK_SQUARE: begin
        open_c  = CH_SQUARE_OPEN;
        close_c = CH_SQUARE_CLOSE;
      end
      BK_CURLY: begin
        open_c  = CH_CURLY_OPEN;
        close_c = CH_CURLY_CLOSE;
      end
      default: begin
        open_c   = CH_ROUND_OPEN;
        close_c  = CH_ROUND_CLOSE;
        bk_valid = 1'b0;
      end
    endcase
  end

  // A count above four enables all four separators.
  assign is_sep = ((cfg.sep_count >= 3'd1) && (char_in == cfg.sep_a)) ||
                  ((cfg.sep_count >= 3'd2) && (char_in == cfg.sep_b)) ||
                  ((cfg.sep_count >= 3'd3) && (char_in == cfg.sep_c)) ||
                  ((cfg.sep_count >= 3'd4) && (char_in == cfg.sep_d));

  assign is_open    = bk_valid && (char_in == open_c);
  assign is_close   = bk_valid && (char_in == close_c);
  assign on_bracket = (is_open || is_close) && cfg.drop_brackets;

  // Close lowers the level before the separator test.
  assign err_close = is_close && (state_cur.nest_level == 8'd0);
  assign lvl_a     = (is_close && !err_close) ? state_cur.nest_level - 8'd1
                                              : state_cur.nest_level;

  assign found = (lvl_a == 8'd0) && is_sep;
  assign kept  = !((lvl_a == 8'd0) && (found || on_bracket));

  // Open raises the level after the test, saturating at the limit.
  assign err_ovf = is_open && (lvl_a >= LEVEL_LIMIT);
  assign lvl_b   = (is_open && !err_ovf) ? lvl_a + 8'd1 : lvl_a;

  assign wo_mid = kept || state_cur.word_open;
  assign wend   = wo_mid && (found || line_end);

  always_comb begin
    if (err_close) begin
      err = ERR_EXTRA_CLOSE;
    end else if (err_ovf) begin
      err = ERR_OVERFLOW;
    end else if (wend && !cfg.carry_level && (lvl_b != 8'd0)) begin
      err = ERR_UNMATCHED;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    result.char_kept  = kept;
    result.char_out   = char_in;
    result.word_end   = wend;
    result.level_out  = lvl_b;
    result.error_code = err;

    state_nxt.word_open  = wo_mid && !(found || line_end);
    state_nxt.nest_level = (line_end && !cfg.carry_level) ? 8'd0 : lvl_b;
  end

endmodule

// ----- hdl/paren_aware_word_splitter_top.sv -----
// ----------------------------------------------------------------------------
// paren_aware_word_splitter_top: bracket-aware word splitter
// Splits a character stream into words at separators that sit outside
// bracket nesting, and reports nesting level and errors for every character.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, then in the result
// register, whose contents drive the output channel.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that stalls only when the output does.
// Reset (rst_n low, synchronous): both stages empty, nesting level zero, no
// word in progress, configuration registers at their default values.
// ----------------------------------------------------------------------------
module paren_aware_word_splitter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_in,
  input  logic                            in_line_end,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_char_kept,
  output logic [7:0]                      out_char_out,
  output logic                            out_word_end,
  output logic [7:0]                      out_level_out,
  output logic [1:0]                      out_error_code,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [pws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pws_pkg::*;

  // Configuration registers. The user must write them only while the block is
  // idle; the block does not enforce it; the step logic reads them unshadowed.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_a         <= RST_SEP_A;
      cfg_r.sep_b         <= RST_SEP_B;
      cfg_r.sep_c         <= RST_SEP_C;
      cfg_r.sep_d         <= RST_SEP_D;
      cfg_r.sep_count     <= RST_SEP_COUNT;
      cfg_r.bracket_kind  <= BK_ROUND;
      cfg_r.drop_brackets <= 1'b0;
      cfg_r.carry_level   <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SEP_CHAR_A:    cfg_r.sep_a         <= cfg_wdata[7:0];
        REG_SEP_CHAR_B:    cfg_r.sep_b         <= cfg_wdata[7:0];
        REG_SEP_CHAR_C:    cfg_r.sep_c         <= cfg_wdata[7:0];
        REG_SEP_CHAR_D:    cfg_r.sep_d         <= cfg_wdata[7:0];
        REG_SEP_COUNT:     cfg_r.sep_count     <= cfg_wdata[2:0];
        REG_BRACKET_KIND:  cfg_r.bracket_kind  <= bracket_kind_t'(cfg_wdata[1:0]);
        REG_DROP_BRACKETS: cfg_r.drop_brackets <= cfg_wdata[0];
        REG_CARRY_LEVEL:   cfg_r.carry_level   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage one: the input register. It moves forward whenever the result
  // register is empty or its current result is being taken this cycle.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s2_load;
  logic       in_take;

  assign s2_load  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s2_load || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_line_end;
    end
  end

  // Splitter state: advances exactly once per character, as the character
  // leaves stage one for the result register.
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  logic    s1_fire;

  assign s1_fire = s1_valid_r && s2_load;

  pws_step u_step (
    .cfg       (cfg_r),
    .char_in   (s1_char_r),
    .line_end  (s1_last_r),
    .state_cur (state_r),
    .result    (result_nxt),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Stage two: the result register feeding the output channel.
  logic    out_valid_r;
  result_t result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_kept  = result_r.char_kept;
  assign out_char_out   = result_r.char_out;
  assign out_word_end   = result_r.word_end;
  assign out_level_out  = result_r.level_out;
  assign out_error_code = result_r.error_code;

endmodule

// ----- hdl/pws_checker.sv -----
// ----------------------------------------------------------------------------
// pws_checker: port-level assertions for the word splitter
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
module pws_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_char_kept,
  input logic [7:0]                      out_char_out,
  input logic                            out_word_end,
  input logic [7:0]                      out_level_out,
  input logic [1:0]                      out_error_code
);
  import pws_pkg::*;

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out) &&
      $stable(out_char_kept) && $stable(out_word_end) &&
      $stable(out_level_out) && $stable(out_error_code))
    else $error("stalled result changed");

  // Unmatched is only reported at a word end with brackets still open.
  a_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_UNMATCHED) |->
      out_word_end && (out_level_out != 8'd0))
    else $error("unmatched error without open word end");

  // An extra close leaves the level clamped at zero.
  a_extra_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_EXTRA_CLOSE) |-> out_level_out == 8'd0)
    else $error("extra close with nonzero level");

  // Overflow only happens at the saturation limit, which is never exceeded.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_out <= LEVEL_LIMIT) &&
      ((out_error_code != ERR_OVERFLOW) || (out_level_out == LEVEL_LIMIT)))
    else $error("nesting level beyond limit");

endmodule

bind paren_aware_word_splitter_top pws_checker u_pws_checker (.*);

// ----- sim/paren_aware_word_splitter_top_tb.sv -----
// ----------------------------------------------------------------------------
// paren_aware_word_splitter_top_tb: self-checking bench for the word splitter
// A directed table covers the reset behavior, the extra-close and unmatched
// errors, the bracket kinds, the separator count limits and the level carry;
// a nesting run covers overflow.  Random character streams then run under many
// register settings and three idling patterns.  Every result is checked, field
// by field and in order, against an in-bench model or a hand-typed value.
// ----------------------------------------------------------------------------
module paren_aware_word_splitter_top_tb;
  import pws_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int ITEMS_PER_SEG = 92;
  localparam int DRAIN_CYCLES  = 4;

  localparam cfg_t DEFAULT_CFG = '{RST_SEP_A, RST_SEP_B, RST_SEP_C, RST_SEP_D,
                                   RST_SEP_COUNT, BK_ROUND, 1'b0, 1'b0};

  // One row of the directed table: either a register write or a character.
  // Rows with pinned set carry an expected result typed in by hand.
  typedef struct {
    logic       is_cfg;
    reg_idx_t   idx;
    logic [7:0] val;
    logic [7:0] ch;
    logic       last;
    logic       pinned;
    result_t    res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_in = 8'd0;
  logic                  in_line_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_char_kept;
  logic [7:0]            out_char_out;
  logic                  out_word_end;
  logic [7:0]            out_level_out;
  logic [1:0]            out_error_code;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // The expected result of a hand-checked row travels alongside its request.
  logic                  drv_pinned = 1'b0;
  result_t               drv_pinned_res = '0;

  // Bench copy of the registers and of the splitter state.
  cfg_t                  model_cfg;
  logic [7:0]            model_level;
  logic                  model_word_open;

  result_t               expected_results[$];
  result_t               want;
  result_t               pred;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    send_idle_pct = 13;
  int                    stall_pct = 47;
  dir_row_t              dir_rows[$];

  paren_aware_word_splitter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_kept  (out_char_kept),
    .out_char_out   (out_char_out),
    .out_word_end   (out_word_end),
    .out_level_out  (out_level_out),
    .out_error_code (out_error_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Expected result for one character; this also advances the model state.
  // A closing bracket lowers the level before the separator test, an
  // opening bracket raises it afterwards, and the first error found wins.
  function automatic result_t predict_split(input logic [7:0] ch, input logic last);
    result_t    r;
    logic [7:0] lvl;
    logic [7:0] open_c;
    logic [7:0] close_c;
    logic       has_pair;
    logic       is_open;
    logic       is_close;
    logic       drop_hit;
    logic       found;
    logic       kept;
    logic       wend;
    logic [2:0] n_sep;
    err_t       err;
    lvl      = model_level;
    err      = ERR_NONE;
    wend     = 1'b0;
    has_pair = 1'b1;
    open_c   = 8'd0;
    close_c  = 8'd0;
    case (model_cfg.bracket_kind)
      BK_ROUND: begin
        open_c  = CH_ROUND_OPEN;
        close_c = CH_ROUND_CLOSE;
      end
      BK_SQUARE: begin
        open_c  = CH_SQUARE_OPEN;
        close_c = CH_SQUARE_CLOSE;
      end
      BK_CURLY: begin
        open_c  = CH_CURLY_OPEN;
        close_c = CH_CURLY_CLOSE;
      end
      default: has_pair = 1'b0;
    endcase
    is_open  = has_pair && (ch == open_c);
    is_close = has_pair && (ch == close_c);
    drop_hit = (is_open || is_close) && model_cfg.drop_brackets;

    if (is_close) begin
      if (lvl == 8'd0) err = ERR_EXTRA_CLOSE;
      else lvl = lvl - 8'd1;
    end

    n_sep = (model_cfg.sep_count > 3'd4) ? 3'd4 : model_cfg.sep_count;
    found = (lvl == 8'd0) &&
            ((n_sep >= 3'd1 && ch == model_cfg.sep_a) ||
             (n_sep >= 3'd2 && ch == model_cfg.sep_b) ||
             (n_sep >= 3'd3 && ch == model_cfg.sep_c) ||
             (n_sep >= 3'd4 && ch == model_cfg.sep_d));
    kept = !((lvl == 8'd0) && (found || drop_hit));

    if (is_open) begin
      if (lvl >= LEVEL_LIMIT) begin
        if (err == ERR_NONE) err = ERR_OVERFLOW;
      end else begin
        lvl = lvl + 8'd1;
      end
    end

    if (kept) model_word_open = 1'b1;
    if ((found || last) && model_word_open) begin
      wend = 1'b1;
      if (!model_cfg.carry_level && lvl != 8'd0 && err == ERR_NONE) err = ERR_UNMATCHED;
      model_word_open = 1'b0;
    end

    r = '{kept, ch, wend, lvl, err};
    model_level = (last && !model_cfg.carry_level) ? 8'd0 : lvl;
    return r;
  endfunction

  function automatic logic [7:0] bracket_of(input bracket_kind_t k, input logic closing);
    case (k)
      BK_SQUARE: return closing ? CH_SQUARE_CLOSE : CH_SQUARE_OPEN;
      BK_CURLY:  return closing ? CH_CURLY_CLOSE : CH_CURLY_OPEN;
      default:   return closing ? CH_ROUND_CLOSE : CH_ROUND_OPEN;
    endcase
  endfunction

  // Random character, mostly words, separators and brackets of the active
  // kind, so that the nesting level actually moves.  Deep streams favor
  // opening brackets.
  function automatic logic [7:0] pick_char(input bit deep);
    int            r;
    bracket_kind_t k;
    r = $urandom_range(99);
    k = model_cfg.bracket_kind;
    if (k == BK_NONE) k = bracket_kind_t'($urandom_range(2));
    if (r < 35) return 8'h61 + 8'($urandom_range(25));
    if (r < 50) begin
      case ($urandom_range(3))
        0: return model_cfg.sep_a;
        1: return model_cfg.sep_b;
        2: return model_cfg.sep_c;
        default: return model_cfg.sep_d;
      endcase
    end
    if (r < (deep ? 72 : 62)) return bracket_of(k, 1'b0);
    if (r < (deep ? 76 : 74)) return bracket_of(k, 1'b1);
    if (r < 82) return bracket_of(bracket_kind_t'($urandom_range(2)), 1'($urandom_range(1)));
    return 8'($urandom_range(255));
  endfunction

  // Register settings for one segment: the low extremes first, then the high
  // ones, then random mixes biased toward common separator characters.
  function automatic cfg_t pick_settings(input int seg_no);
    cfg_t c;
    logic [7:0] pool[8];
    pool = '{8'h20, 8'h09, 8'h0A, 8'h2C, 8'h3B, CH_ROUND_OPEN, CH_SQUARE_CLOSE, 8'h00};
    if (seg_no == 0) return '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, BK_ROUND, 1'b0, 1'b0};
    if (seg_no == 1) return '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, BK_CURLY, 1'b1, 1'b1};
    c.sep_a = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(7)];
    c.sep_b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(7)];
    c.sep_c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(7)];
    c.sep_d = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pool[$urandom_range(7)];
    c.sep_count     = 3'($urandom_range(7));
    c.bracket_kind  = bracket_kind_t'($urandom_range(3));
    c.drop_brackets = 1'($urandom_range(1));
    c.carry_level   = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic dir_row_t char_row(input logic [7:0] ch, input logic last);
    dir_row_t d;
    d = '{1'b0, REG_SEP_CHAR_A, 8'd0, ch, last, 1'b0, '0};
    return d;
  endfunction

  function automatic dir_row_t pin_row(input logic [7:0] ch, input logic last,
                                       input logic kept, input logic wend,
                                       input logic [7:0] lvl, input err_t err);
    dir_row_t d;
    d = '{1'b0, REG_SEP_CHAR_A, 8'd0, ch, last, 1'b1, '{kept, ch, wend, lvl, err}};
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input reg_idx_t idx, input logic [7:0] val);
    dir_row_t d;
    d = '{1'b1, idx, val, 8'd0, 1'b0, 1'b0, '0};
    return d;
  endfunction

  // Appends one row at the end of the directed table.
  function automatic void add_row(input dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Present one request and hold it until the splitter takes it.  Called and
  // returning at a falling edge; valid stays high for a back-to-back request.
  task automatic push_char(input logic [7:0] ch, input logic last,
                           input logic pinned, input result_t pin_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_char_in     <= ch;
    in_line_end    <= last;
    drv_pinned     <= pinned;
    drv_pinned_res <= pin_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come out, plus
  // DRAIN_CYCLES more so the pipeline is surely empty.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller lowers the write enable afterwards so
  // that back-to-back writes keep it high.
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SEP_CHAR_A:    model_cfg.sep_a = val;
      REG_SEP_CHAR_B:    model_cfg.sep_b = val;
      REG_SEP_CHAR_C:    model_cfg.sep_c = val;
      REG_SEP_CHAR_D:    model_cfg.sep_d = val;
      REG_SEP_COUNT:     model_cfg.sep_count = val[2:0];
      REG_BRACKET_KIND:  model_cfg.bracket_kind = bracket_kind_t'(val[1:0]);
      REG_DROP_BRACKETS: model_cfg.drop_brackets = val[0];
      REG_CARRY_LEVEL:   model_cfg.carry_level = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_all(input cfg_t c);
    write_reg(REG_SEP_CHAR_A, c.sep_a);
    write_reg(REG_SEP_CHAR_B, c.sep_b);
    write_reg(REG_SEP_CHAR_C, c.sep_c);
    write_reg(REG_SEP_CHAR_D, c.sep_d);
    write_reg(REG_SEP_COUNT, {5'd0, c.sep_count});
    write_reg(REG_BRACKET_KIND, {6'd0, c.bracket_kind});
    write_reg(REG_DROP_BRACKETS, {7'd0, c.drop_brackets});
    write_reg(REG_CARRY_LEVEL, {7'd0, c.carry_level});
    cfg_we <= 1'b0;
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Scoreboard.  At each rising edge a result leaving the splitter is checked
  // against the oldest expectation first; then an accepted request gets its
  // prediction queued.  A result never leaves in the cycle of its own request,
  // so this order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result for char %02h", out_char_out));
        end else begin
          want = expected_results.pop_front();
          if (out_char_kept !== want.char_kept)
            report_mismatch($sformatf("char %02h char_kept %b, want %b",
                                      want.char_out, out_char_kept, want.char_kept));
          if (out_char_out !== want.char_out)
            report_mismatch($sformatf("char_out %02h, want %02h", out_char_out, want.char_out));
          if (out_word_end !== want.word_end)
            report_mismatch($sformatf("char %02h word_end %b, want %b",
                                      want.char_out, out_word_end, want.word_end));
          if (out_level_out !== want.level_out)
            report_mismatch($sformatf("char %02h level_out %0d, want %0d",
                                      want.char_out, out_level_out, want.level_out));
          if (out_error_code !== want.error_code)
            report_mismatch($sformatf("char %02h error_code %0d, want %0d",
                                      want.char_out, out_error_code, want.error_code));
        end
      end
      if (in_valid && !in_stall) begin
        // The model always runs so its state stays in step; a hand-checked
        // row replaces its prediction with the typed-in value.
        pred = predict_split(in_char_in, in_line_end);
        expected_results.insert(expected_results.size(), drv_pinned ? drv_pinned_res : pred);
      end
    end
  end

  initial begin
    int       phase;
    int       seg;
    int       k;
    int       seg_no;
    bit       deep;
    logic     last;
    dir_row_t row;

    model_cfg       = DEFAULT_CFG;
    model_level     = 8'd0;
    model_word_open = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.  The first rows run on the reset settings: space, tab
    // and line feed separate, round brackets nest, nothing is dropped.
    add_row(pin_row(8'h61, 1'b0, 1'b1, 1'b0, 8'd0, ERR_NONE));
    add_row(pin_row(8'h20, 1'b0, 1'b0, 1'b1, 8'd0, ERR_NONE));
    // A close at level zero stays at zero and flags an extra close.
    add_row(pin_row(CH_ROUND_CLOSE, 1'b0, 1'b1, 1'b0, 8'd0, ERR_EXTRA_CLOSE));
    add_row(pin_row(CH_ROUND_OPEN, 1'b0, 1'b1, 1'b0, 8'd1, ERR_NONE));
    // Inside brackets a space is an ordinary character.
    add_row(pin_row(8'h20, 1'b0, 1'b1, 1'b0, 8'd1, ERR_NONE));
    // The line ends with the bracket still open: the word ends, unmatched.
    add_row(pin_row(8'h78, 1'b1, 1'b1, 1'b1, 8'd1, ERR_UNMATCHED));
    // NUL is the fourth separator, which is inactive with a count of three.
    add_row(pin_row(8'h00, 1'b0, 1'b1, 1'b0, 8'd0, ERR_NONE));
    add_row(pin_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'd0, ERR_NONE));
    add_row(pin_row(8'h09, 1'b0, 1'b0, 1'b0, 8'd0, ERR_NONE));
    // A line end with no word in progress completes nothing.
    add_row(pin_row(8'h0A, 1'b1, 1'b0, 1'b0, 8'd0, ERR_NONE));
    // Brackets at level zero are dropped from the word.
    add_row(cfg_row(REG_DROP_BRACKETS, 8'd1));
    add_row(char_row(CH_ROUND_OPEN, 1'b0));
    add_row(char_row(CH_ROUND_CLOSE, 1'b0));
    add_row(char_row(8'h20, 1'b1));
    add_row(cfg_row(REG_BRACKET_KIND, {6'd0, BK_CURLY}));
    add_row(char_row(CH_CURLY_OPEN, 1'b0));
    add_row(char_row(CH_CURLY_CLOSE, 1'b1));
    // With no bracket pair selected, nothing nests.
    add_row(cfg_row(REG_BRACKET_KIND, {6'd0, BK_NONE}));
    add_row(char_row(CH_ROUND_OPEN, 1'b0));
    add_row(char_row(CH_ROUND_CLOSE, 1'b1));
    // A count above four enables all four separators.
    add_row(cfg_row(REG_SEP_COUNT, 8'd7));
    add_row(cfg_row(REG_SEP_CHAR_D, 8'h2C));
    add_row(char_row(8'h63, 1'b0));
    add_row(char_row(8'h2C, 1'b1));
    // A count of zero disables every separator.
    add_row(cfg_row(REG_SEP_COUNT, 8'd0));
    add_row(char_row(8'h20, 1'b0));
    add_row(char_row(8'h64, 1'b1));
    // A closing bracket that is also a separator closes first, then splits.
    add_row(cfg_row(REG_BRACKET_KIND, {6'd0, BK_ROUND}));
    add_row(cfg_row(REG_SEP_COUNT, 8'd1));
    add_row(cfg_row(REG_SEP_CHAR_A, CH_ROUND_CLOSE));
    add_row(char_row(CH_ROUND_OPEN, 1'b0));
    add_row(char_row(8'h65, 1'b0));
    add_row(char_row(CH_ROUND_CLOSE, 1'b1));
    // An opening bracket that is also a separator splits first, then opens.
    add_row(cfg_row(REG_SEP_CHAR_A, CH_ROUND_OPEN));
    add_row(char_row(CH_ROUND_OPEN, 1'b0));
    add_row(char_row(CH_ROUND_CLOSE, 1'b1));
    // Carrying the level across lines skips the unmatched check.
    add_row(cfg_row(REG_CARRY_LEVEL, 8'd1));
    add_row(char_row(CH_ROUND_OPEN, 1'b0));
    add_row(char_row(8'h66, 1'b1));
    add_row(char_row(CH_ROUND_CLOSE, 1'b1));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_for_results();
        write_reg(row.idx, row.val);
        cfg_we <= 1'b0;
      end else begin
        push_char(row.ch, row.last, row.pinned, row.res);
      end
    end

    // Nesting overflow: fill the level to its limit, then one more open
    // must leave the level unchanged and flag.  The line then ends with the
    // brackets still open.
    wait_for_results();
    program_all(DEFAULT_CFG);
    repeat (LEVEL_LIMIT_INT) push_char(CH_ROUND_OPEN, 1'b0, 1'b0, '0);
    push_char(CH_ROUND_OPEN, 1'b0, 1'b1,
              '{1'b1, CH_ROUND_OPEN, 1'b0, LEVEL_LIMIT, ERR_OVERFLOW});
    push_char(CH_ROUND_CLOSE, 1'b1, 1'b1,
              '{1'b1, CH_ROUND_CLOSE, 1'b1, LEVEL_LIMIT - 8'd1, ERR_UNMATCHED});

    // Random streams: three idling patterns, four register settings each.
    seg_no = 0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          stall_pct     = 47;
        end
        1: begin
          send_idle_pct = 47;
          stall_pct     = 13;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        wait_for_results();
        program_all(pick_settings(seg_no));
        deep = (seg_no % 3 == 2);
        for (k = 0; k < ITEMS_PER_SEG; k++) begin
          // Once mid-stream the sender holds off until the pipeline is empty.
          if (seg_no == 2 && k == ITEMS_PER_SEG / 2) wait_for_results();
          last = deep ? ($urandom_range(39) == 0) : ($urandom_range(11) == 0);
          push_char(pick_char(deep), last, 1'b0, '0);
        end
        seg_no++;
      end
    end

    wait_for_results();
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
